FILE: rtl/ps2hbt_pkg.sv
// Package for the PS/2 host byte transceiver: item structs, phase and status codes,
// configuration register indexes and defaults. No dependencies.
package ps2hbt_pkg;

	localparam int TIMER_BITS_DEF = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIMEOUT   = 2'd3;

	localparam logic [CFG_W-1:0] INHIBIT_TICKS_RST = 16'd105;
	localparam logic [CFG_W-1:0] RELEASE_TICKS_RST = 16'd20;
	localparam logic [CFG_W-1:0] FIRST_TIMEOUT_RST = 16'd9000;
	localparam logic [CFG_W-1:0] BIT_TIMEOUT_RST   = 16'd1500;

	localparam logic [2:0] ST_NONE       = 3'd0;
	localparam logic [2:0] ST_RX_OK      = 3'd1;
	localparam logic [2:0] ST_RX_PARITY  = 3'd2;
	localparam logic [2:0] ST_RX_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_TX_DONE    = 3'd4;
	localparam logic [2:0] ST_TX_TIMEOUT = 3'd5;

	// frame bit counts
	localparam logic [3:0] DATA_BITS   = 4'd8;
	localparam logic [3:0] RX_LAST_BIT = 4'd9;
	localparam logic [3:0] TX_END_BITS = 4'd10;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RX,
		PH_RX_STOP,
		PH_TX_INHIBIT,
		PH_TX_DATLOW,
		PH_TX_FIRST,
		PH_TX_BITS,
		PH_TX_ACK
	} phase_t;

	typedef struct packed {
		logic       req_type;
		logic       line_clk;
		logic       line_dat;
		logic [7:0] send_byte;
	} in_item_t;

	typedef struct packed {
		logic       pull_clk_low;
		logic       pull_dat_low;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic [2:0] status;
	} out_item_t;

	// queue entry: the line sample plus the odd parity bit worked out up front
	typedef struct packed {
		in_item_t smp;
		logic     tx_par;
	} q_item_t;

endpackage

FILE: rtl/ps2hbt_queue.sv
// Two-entry request queue between the front and the line engine.
// Depends on ps2hbt_pkg.
module ps2hbt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ps2hbt_pkg::q_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ps2hbt_pkg::q_item_t head_item
);

	ps2hbt_pkg::q_item_t                        mem [ps2hbt_pkg::Q_DEPTH];
	logic [ps2hbt_pkg::Q_PTR_W-1:0]             wr_ptr_q;
	logic [ps2hbt_pkg::Q_PTR_W-1:0]             rd_ptr_q;
	logic [ps2hbt_pkg::Q_CNT_W-1:0]             cnt_q;

	localparam logic [ps2hbt_pkg::Q_PTR_W-1:0] LAST = ps2hbt_pkg::Q_PTR_W'(ps2hbt_pkg::Q_DEPTH - 1);
	localparam logic [ps2hbt_pkg::Q_CNT_W-1:0] DEPTH_C = ps2hbt_pkg::Q_CNT_W'(ps2hbt_pkg::Q_DEPTH);

	assign full       = (cnt_q == DEPTH_C);
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/ps2hbt_engine.sv
// Line engine: frame state machine, tick timer, config registers and result register.
// Depends on ps2hbt_pkg.
module ps2hbt_engine #(
	parameter int TIMER_BITS = ps2hbt_pkg::TIMER_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  head_valid,
	input  ps2hbt_pkg::q_item_t                   head_item,
	output logic                                  pop,
	input  logic                                  cfg_we,
	input  logic [ps2hbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ps2hbt_pkg::CFG_W-1:0]          cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output ps2hbt_pkg::out_item_t                 out_data
);

	localparam int CMP_W = (TIMER_BITS > ps2hbt_pkg::CFG_W) ? TIMER_BITS : ps2hbt_pkg::CFG_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

	logic [ps2hbt_pkg::CFG_W-1:0] inhibit_q, release_q, first_to_q, bit_to_q;

	ps2hbt_pkg::phase_t     phase_q, phase_d;
	logic [3:0]             bcnt_q, bcnt_d;
	logic [7:0]             shift_q, shift_d;
	logic                   par_q, par_d;
	logic [TIMER_BITS-1:0]  cnt_q, cnt_d, cnt_inc;
	logic                   prev_clk_q;
	logic [2:0]             status_d;
	logic [7:0]             rxb_d;
	logic                   out_valid_q;
	ps2hbt_pkg::out_item_t  out_q, res_d;

	logic fall, rise, edge_seen, smp_clk, smp_dat;
	logic hit_bit, hit_first, hit_inh, hit_rel;
	logic step;

	assign smp_clk = head_item.smp.line_clk;
	assign smp_dat = head_item.smp.line_dat;

	assign step      = head_valid && (!out_valid_q || out_ready);
	assign pop       = step;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign fall      = prev_clk_q && !smp_clk;
	assign rise      = !prev_clk_q && smp_clk;
	assign edge_seen = prev_clk_q ^ smp_clk;

	// saturating count and limit compares
	assign cnt_inc   = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign hit_bit   = (CMP_W'(cnt_inc) >= CMP_W'(bit_to_q))   || (cnt_inc == CNT_MAX);
	assign hit_first = (CMP_W'(cnt_inc) >= CMP_W'(first_to_q)) || (cnt_inc == CNT_MAX);
	assign hit_inh   = (CMP_W'(cnt_inc) >= CMP_W'(inhibit_q))  || (cnt_inc == CNT_MAX);
	assign hit_rel   = (CMP_W'(cnt_inc) >= CMP_W'(release_q))  || (cnt_inc == CNT_MAX);

	// next state
	always_comb begin
		phase_d  = phase_q;
		bcnt_d   = bcnt_q;
		shift_d  = shift_q;
		par_d    = par_q;
		cnt_d    = cnt_q;
		status_d = ps2hbt_pkg::ST_NONE;
		rxb_d    = '0;
		case (phase_q)
			ps2hbt_pkg::PH_IDLE: begin
				if (head_item.smp.req_type) begin
					shift_d = head_item.smp.send_byte;
					par_d   = head_item.tx_par;
					bcnt_d  = '0;
					cnt_d   = '0;
					phase_d = ps2hbt_pkg::PH_TX_INHIBIT;
				end else if (!smp_clk && !smp_dat) begin
					shift_d = '0;
					par_d   = 1'b0;
					bcnt_d  = '0;
					cnt_d   = '0;
					phase_d = ps2hbt_pkg::PH_RX;
				end
			end
			ps2hbt_pkg::PH_RX, ps2hbt_pkg::PH_RX_STOP: begin
				if (edge_seen) begin
					cnt_d = '0;
					if (phase_q == ps2hbt_pkg::PH_RX && fall) begin
						if (bcnt_q < ps2hbt_pkg::DATA_BITS) begin
							shift_d = {smp_dat, shift_q[7:1]};
							par_d   = par_q ^ smp_dat;
							bcnt_d  = bcnt_q + 1'b1;
						end else if (bcnt_q == ps2hbt_pkg::DATA_BITS) begin
							par_d  = par_q ^ smp_dat;
							bcnt_d = ps2hbt_pkg::RX_LAST_BIT;
						end else begin
							phase_d = ps2hbt_pkg::PH_RX_STOP;
						end
					end else if (phase_q == ps2hbt_pkg::PH_RX_STOP && rise) begin
						if (par_q) begin
							status_d = ps2hbt_pkg::ST_RX_OK;
							rxb_d    = shift_q;
						end else begin
							status_d = ps2hbt_pkg::ST_RX_PARITY;
						end
						phase_d = ps2hbt_pkg::PH_IDLE;
					end
				end else begin
					cnt_d = cnt_inc;
					if (hit_bit) begin
						status_d = ps2hbt_pkg::ST_RX_TIMEOUT;
						phase_d  = ps2hbt_pkg::PH_IDLE;
					end
				end
			end
			ps2hbt_pkg::PH_TX_INHIBIT: begin
				cnt_d = cnt_inc;
				if (hit_inh) begin
					cnt_d   = '0;
					phase_d = ps2hbt_pkg::PH_TX_DATLOW;
				end
			end
			ps2hbt_pkg::PH_TX_DATLOW: begin
				cnt_d = cnt_inc;
				if (hit_rel) begin
					cnt_d   = '0;
					phase_d = ps2hbt_pkg::PH_TX_FIRST;
				end
			end
			ps2hbt_pkg::PH_TX_FIRST: begin
				if (fall) begin
					cnt_d   = '0;
					bcnt_d  = '0;
					phase_d = ps2hbt_pkg::PH_TX_BITS;
				end else begin
					cnt_d = cnt_inc;
					if (hit_first) begin
						status_d = ps2hbt_pkg::ST_TX_TIMEOUT;
						phase_d  = ps2hbt_pkg::PH_IDLE;
					end
				end
			end
			ps2hbt_pkg::PH_TX_BITS, ps2hbt_pkg::PH_TX_ACK: begin
				if (edge_seen) begin
					cnt_d = '0;
					if (phase_q == ps2hbt_pkg::PH_TX_BITS && fall) begin
						if (bcnt_q < ps2hbt_pkg::DATA_BITS) begin
							shift_d = {1'b0, shift_q[7:1]};
						end
						bcnt_d = bcnt_q + 1'b1;
						if (bcnt_q + 1'b1 >= ps2hbt_pkg::TX_END_BITS) begin
							phase_d = ps2hbt_pkg::PH_TX_ACK;
						end
					end else if (phase_q == ps2hbt_pkg::PH_TX_ACK && rise) begin
						status_d = ps2hbt_pkg::ST_TX_DONE;
						phase_d  = ps2hbt_pkg::PH_IDLE;
					end
				end else begin
					cnt_d = cnt_inc;
					if (hit_bit) begin
						status_d = ps2hbt_pkg::ST_TX_TIMEOUT;
						phase_d  = ps2hbt_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = ps2hbt_pkg::PH_IDLE;
			end
		endcase
	end

	// line drives follow the phase after this tick
	always_comb begin
		res_d              = '0;
		res_d.pull_clk_low = (phase_d inside {ps2hbt_pkg::PH_TX_INHIBIT, ps2hbt_pkg::PH_TX_DATLOW});
		res_d.busy_res     = (phase_d != ps2hbt_pkg::PH_IDLE);
		res_d.rx_byte      = rxb_d;
		res_d.status       = status_d;
		case (phase_d)
			ps2hbt_pkg::PH_TX_DATLOW, ps2hbt_pkg::PH_TX_FIRST: begin
				res_d.pull_dat_low = 1'b1;
			end
			ps2hbt_pkg::PH_TX_BITS: begin
				if (bcnt_d < ps2hbt_pkg::DATA_BITS) begin
					res_d.pull_dat_low = !shift_d[0];
				end else if (bcnt_d == ps2hbt_pkg::DATA_BITS) begin
					res_d.pull_dat_low = !par_d;
				end
			end
			default: begin
				res_d.pull_dat_low = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ps2hbt_pkg::PH_IDLE;
			bcnt_q      <= '0;
			shift_q     <= '0;
			par_q       <= 1'b0;
			cnt_q       <= '0;
			prev_clk_q  <= 1'b1;
			out_valid_q <= 1'b0;
			inhibit_q   <= ps2hbt_pkg::INHIBIT_TICKS_RST;
			release_q   <= ps2hbt_pkg::RELEASE_TICKS_RST;
			first_to_q  <= ps2hbt_pkg::FIRST_TIMEOUT_RST;
			bit_to_q    <= ps2hbt_pkg::BIT_TIMEOUT_RST;
		end else begin
			if (step) begin
				phase_q    <= phase_d;
				bcnt_q     <= bcnt_d;
				shift_q    <= shift_d;
				par_q      <= par_d;
				cnt_q      <= cnt_d;
				prev_clk_q <= smp_clk;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					ps2hbt_pkg::CFG_INHIBIT_TICKS: inhibit_q  <= cfg_data;
					ps2hbt_pkg::CFG_RELEASE_TICKS: release_q  <= cfg_data;
					ps2hbt_pkg::CFG_FIRST_TIMEOUT: first_to_q <= cfg_data;
					ps2hbt_pkg::CFG_BIT_TIMEOUT:   bit_to_q   <= cfg_data;
					default: begin
						bit_to_q <= bit_to_q;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/ps2hbt_front.sv
// Request front: adds the transmit parity bit to each line sample and stages it for the queue.
// Depends on ps2hbt_pkg.
module ps2hbt_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ps2hbt_pkg::in_item_t in_data,
	input  logic                 q_full,
	output logic                 q_push,
	output ps2hbt_pkg::q_item_t  q_item
);

	assign in_ready      = !q_full;
	assign q_push        = in_valid && !q_full;
	assign q_item.smp    = in_data;
	// odd parity bit for a transmit request, ready before the engine needs it
	assign q_item.tx_par = ~(^in_data.send_byte);

endmodule

FILE: rtl/ps2_host_byte_transceiver.sv
// PS/2 host byte transceiver, top level: front, request queue and line engine.
// Depends on ps2hbt_pkg, ps2hbt_front, ps2hbt_queue and ps2hbt_engine.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one request per line tick, carrying
//    the sampled clock and data levels and, with req_type set, a byte to send.
//  - Output channel (out_valid/out_ready/out_data): exactly one result per request,
//    in order: the line drives for that tick, busy flag, received byte and status.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//    the four timing registers only while no request is in flight.
//  - Path: a request goes through the queue, then the engine's result register.
//  - Throughput: one request per cycle unless out_ready stalls the result register;
//    each request is a single pass through the engine's next-state logic, with the
//    previous clock sample kept for edges.
//  - A two-entry queue parts the front from the engine; while the receiver holds
//    out_ready low the result register holds, the queue fills, and in_ready drops
//    once both entries are taken.
//  - Reset: phase idle, timer and shift state cleared, previous clock sample high,
//    timing registers back to their defaults, queue and result register empty.
module ps2_host_byte_transceiver #(
	parameter int TIMER_BITS = ps2hbt_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ps2hbt_pkg::in_item_t             in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ps2hbt_pkg::out_item_t            out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ps2hbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ps2hbt_pkg::CFG_W-1:0]     cfg_data
);

	logic                q_push, q_full, q_pop, q_head_valid;
	ps2hbt_pkg::q_item_t q_item, q_head;

	// config writes are always accepted
	assign cfg_ready = 1'b1;

	// accept the request and add its transmit parity bit
	ps2hbt_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	// hold requests while the engine is stalled
	ps2hbt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head)
	);

	// advance the frame state machine one tick per request
	ps2hbt_engine #(
		.TIMER_BITS (TIMER_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

FILE: rtl/ps2hbt_checker.sv
// Port-level checker for the PS/2 host byte transceiver, bound to the top level.
// Depends on ps2hbt_pkg and ps2_host_byte_transceiver.
module ps2hbt_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input ps2hbt_pkg::out_item_t out_data
);

	// a result waiting on the receiver stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// the byte shows only on a good receive
	a_rx_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ps2hbt_pkg::ST_RX_OK |-> out_data.rx_byte == '0)
		else $error("rx byte without rx ok");

	// a reported frame end already shows the line released and idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ps2hbt_pkg::ST_NONE |->
			!out_data.busy_res && !out_data.pull_clk_low && !out_data.pull_dat_low)
		else $error("frame end not idle");

	// line drives only within a frame
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.pull_clk_low || out_data.pull_dat_low) |-> out_data.busy_res)
		else $error("line driven while idle");

endmodule

bind ps2_host_byte_transceiver ps2hbt_checker u_ps2hbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for ps2_host_byte_transceiver: drives line-sample requests, predicts every
// result in-line and checks each field. Depends on ps2hbt_pkg and the transceiver RTL.
module tb;

	// clock, reset and DUT ports; every input is known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	ps2hbt_pkg::in_item_t  in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	ps2hbt_pkg::out_item_t out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [ps2hbt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ps2hbt_pkg::CFG_W-1:0]     cfg_data = '0;

	always #6 clk = ~clk;

	ps2_host_byte_transceiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// line samples waiting to be offered, and line results owed by the DUT
	ps2hbt_pkg::in_item_t  tick_feed[$];
	ps2hbt_pkg::out_item_t due_results[$];
	int        fed_total = 0;
	int        checked_total = 0;
	int        fail_count = 0;
	logic      long_hold_go = 1'b0;

	// shadow of the line engine: frame phase, bit position, shifter, parity, timer
	ps2hbt_pkg::phase_t                    eng_ph;
	logic [3:0]                            eng_bits;
	logic [7:0]                            eng_shift;
	logic                                  eng_par;
	logic [ps2hbt_pkg::TIMER_BITS_DEF-1:0] eng_timer;
	logic                                  eng_prev_clk;
	logic [ps2hbt_pkg::CFG_W-1:0]          lim_inhibit, lim_release, lim_first, lim_bit;

	task automatic engine_reset();
		eng_ph = ps2hbt_pkg::PH_IDLE;
		eng_bits = '0;
		eng_shift = '0;
		eng_par = 1'b0;
		eng_timer = '0;
		eng_prev_clk = 1'b1;
		lim_inhibit = ps2hbt_pkg::INHIBIT_TICKS_RST;
		lim_release = ps2hbt_pkg::RELEASE_TICKS_RST;
		lim_first = ps2hbt_pkg::FIRST_TIMEOUT_RST;
		lim_bit = ps2hbt_pkg::BIT_TIMEOUT_RST;
	endtask

	// advance the wait timer by one tick; true once the limit is reached or it saturates
	function automatic bit timer_up(input logic [ps2hbt_pkg::CFG_W-1:0] lim);
		if (eng_timer != '1)
			eng_timer = eng_timer + 1'b1;
		return (eng_timer >= lim) || (eng_timer == '1);
	endfunction

	// run one line tick through the shadow engine and queue the result it owes
	task automatic predict_line_tick(input ps2hbt_pkg::in_item_t s);
		ps2hbt_pkg::out_item_t r;
		logic                  fall, rise, chg;
		fall = eng_prev_clk && !s.line_clk;
		rise = !eng_prev_clk && s.line_clk;
		chg = eng_prev_clk != s.line_clk;
		r = '0;
		r.status = ps2hbt_pkg::ST_NONE;
		case (eng_ph)
			ps2hbt_pkg::PH_IDLE: begin
				// a send request beats a receive start seen on the same tick
				if (s.req_type) begin
					eng_shift = s.send_byte;
					eng_par = ~^s.send_byte;
					eng_bits = '0;
					eng_timer = '0;
					eng_ph = ps2hbt_pkg::PH_TX_INHIBIT;
				end else if (!s.line_clk && !s.line_dat) begin
					eng_shift = '0;
					eng_par = 1'b0;
					eng_bits = '0;
					eng_timer = '0;
					eng_ph = ps2hbt_pkg::PH_RX;
				end
			end
			ps2hbt_pkg::PH_RX, ps2hbt_pkg::PH_RX_STOP: begin
				if (chg) begin
					eng_timer = '0;
					if (eng_ph == ps2hbt_pkg::PH_RX && fall) begin
						if (eng_bits < ps2hbt_pkg::DATA_BITS) begin
							eng_shift = {s.line_dat, eng_shift[7:1]};
							eng_par = eng_par ^ s.line_dat;
							eng_bits = eng_bits + 1'b1;
						end else if (eng_bits == ps2hbt_pkg::DATA_BITS) begin
							eng_par = eng_par ^ s.line_dat;
							eng_bits = ps2hbt_pkg::RX_LAST_BIT;
						end else begin
							eng_ph = ps2hbt_pkg::PH_RX_STOP;
						end
					end else if (eng_ph == ps2hbt_pkg::PH_RX_STOP && rise) begin
						// stop bit value is not looked at, only the parity total
						if (eng_par) begin
							r.status = ps2hbt_pkg::ST_RX_OK;
							r.rx_byte = eng_shift;
						end else begin
							r.status = ps2hbt_pkg::ST_RX_PARITY;
						end
						eng_ph = ps2hbt_pkg::PH_IDLE;
					end
				end else if (timer_up(lim_bit)) begin
					r.status = ps2hbt_pkg::ST_RX_TIMEOUT;
					eng_ph = ps2hbt_pkg::PH_IDLE;
				end
			end
			ps2hbt_pkg::PH_TX_INHIBIT: begin
				if (timer_up(lim_inhibit)) begin
					eng_timer = '0;
					eng_ph = ps2hbt_pkg::PH_TX_DATLOW;
				end
			end
			ps2hbt_pkg::PH_TX_DATLOW: begin
				if (timer_up(lim_release)) begin
					eng_timer = '0;
					eng_ph = ps2hbt_pkg::PH_TX_FIRST;
				end
			end
			ps2hbt_pkg::PH_TX_FIRST: begin
				if (fall) begin
					eng_timer = '0;
					eng_bits = '0;
					eng_ph = ps2hbt_pkg::PH_TX_BITS;
				end else if (timer_up(lim_first)) begin
					r.status = ps2hbt_pkg::ST_TX_TIMEOUT;
					eng_ph = ps2hbt_pkg::PH_IDLE;
				end
			end
			ps2hbt_pkg::PH_TX_BITS, ps2hbt_pkg::PH_TX_ACK: begin
				if (chg) begin
					eng_timer = '0;
					if (eng_ph == ps2hbt_pkg::PH_TX_BITS && fall) begin
						if (eng_bits < ps2hbt_pkg::DATA_BITS)
							eng_shift = eng_shift >> 1;
						eng_bits = eng_bits + 1'b1;
						if (eng_bits >= ps2hbt_pkg::TX_END_BITS)
							eng_ph = ps2hbt_pkg::PH_TX_ACK;
					end else if (eng_ph == ps2hbt_pkg::PH_TX_ACK && rise) begin
						r.status = ps2hbt_pkg::ST_TX_DONE;
						eng_ph = ps2hbt_pkg::PH_IDLE;
					end
				end else if (timer_up(lim_bit)) begin
					r.status = ps2hbt_pkg::ST_TX_TIMEOUT;
					eng_ph = ps2hbt_pkg::PH_IDLE;
				end
			end
			default: begin
				eng_ph = ps2hbt_pkg::PH_IDLE;
			end
		endcase
		eng_prev_clk = s.line_clk;

		// line drives follow the phase after this tick's update
		r.pull_clk_low = (eng_ph == ps2hbt_pkg::PH_TX_INHIBIT) ||
			(eng_ph == ps2hbt_pkg::PH_TX_DATLOW);
		if (eng_ph == ps2hbt_pkg::PH_TX_DATLOW || eng_ph == ps2hbt_pkg::PH_TX_FIRST) begin
			r.pull_dat_low = 1'b1;
		end else if (eng_ph == ps2hbt_pkg::PH_TX_BITS) begin
			if (eng_bits < ps2hbt_pkg::DATA_BITS)
				r.pull_dat_low = ~eng_shift[0];
			else if (eng_bits == ps2hbt_pkg::DATA_BITS)
				r.pull_dat_low = ~eng_par;
		end
		r.busy_res = eng_ph != ps2hbt_pkg::PH_IDLE;
		due_results.push_back(r);
	endtask

	// ---------------------------------------------------------------- driver
	// Offer queued line samples in bursts of random length with random gaps.
	// Valid holds with its payload until the DUT takes the request.
	int burst_left, gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			// the sample leaving now is the next tick the engine sees
			if (in_valid && in_ready)
				predict_line_tick(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (tick_feed.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= tick_feed.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 64);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// -------------------------------------------------------------- receiver
	// Stall on a pattern that switches mode now and then; once on request,
	// hold off for a long stretch so the internal queue fills and in_ready drops.
	int stall_mode, mode_left, long_left;
	logic long_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			long_left <= 0;
			long_done <= 1'b0;
		end else if (long_hold_go && !long_done) begin
			long_done <= 1'b1;
			long_left <= 200;
			out_ready <= 1'b0;
		end else if (long_left != 0) begin
			long_left <= long_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// --------------------------------------------------------------- monitor
	task automatic check_field(input string fname, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		ps2hbt_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			checked_total++;
			if (due_results.size() == 0) begin
				$error("line result with no request waiting: %h", out_data);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				check_field("pull_clk_low", 8'(want.pull_clk_low),
					8'(out_data.pull_clk_low));
				check_field("pull_dat_low", 8'(want.pull_dat_low),
					8'(out_data.pull_dat_low));
				check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
				check_field("rx_byte", want.rx_byte, out_data.rx_byte);
				check_field("status", 8'(want.status), 8'(out_data.status));
			end
		end
	end

	// ------------------------------------------------------ stimulus helpers
	task automatic feed(input logic req, input logic lc, input logic ld,
			input logic [7:0] b);
		ps2hbt_pkg::in_item_t it;
		it.req_type = req;
		it.line_clk = lc;
		it.line_dat = ld;
		it.send_byte = b;
		tick_feed.push_back(it);
		fed_total++;
	endtask

	// hold both lines for n ticks; mid-frame, sprinkle requests the busy engine must drop
	task automatic hold_line(input logic lc, input logic ld, input int n, input bit stray);
		int i;
		for (i = 0; i < n; i++)
			feed(stray && ($urandom_range(0, 11) == 0), lc, ld, 8'($urandom_range(0, 255)));
	endtask

	// hold length that keeps the bit timer short of its limit
	function automatic int pick_hold(input int hmax);
		return $urandom_range(1, hmax);
	endfunction

	// device-to-host frame: start, 8 data bits, parity, stop; cut short unless done
	task automatic rx_frame(input logic [7:0] b, input bit bad_par, input int falls,
			input bit done, input int hmax);
		int   k;
		logic bv;
		feed(1'b0, 1'b0, 1'b0, 8'($urandom_range(0, 255)));
		hold_line(1'b0, 1'b0, pick_hold(hmax) - 1, 1);
		for (k = 0; k < falls; k++) begin
			if (k < 8)
				bv = b[k];
			else if (k == 8)
				bv = (~^b) ^ bad_par;
			else
				bv = 1'($urandom_range(0, 1));
			hold_line(1'b1, 1'($urandom_range(0, 1)), pick_hold(hmax), 1);
			hold_line(1'b0, bv, pick_hold(hmax), 1);
		end
		if (done)
			hold_line(1'b1, 1'b1, 1, 1);
		else
			hold_line(1'b0, 1'b1, int'(lim_bit) + 2, 0);
	endtask

	// host-to-device frame: request, inhibit and release padding, then device clocks
	task automatic tx_frame(input logic [7:0] b, input bit together, input int slack,
			input int falls, input bit done, input int hmax);
		int k;
		if (together)
			feed(1'b1, 1'b0, 1'b0, b);
		else
			feed(1'b1, 1'b1, 1'($urandom_range(0, 1)), b);
		// padding runs past the timeout when slack is too big; no stray requests then
		hold_line(1'b1, 1'($urandom_range(0, 1)),
			int'(lim_inhibit) + int'(lim_release) + slack, slack < int'(lim_first));
		for (k = 0; k < falls; k++) begin
			if (k > 0)
				hold_line(1'b1, 1'($urandom_range(0, 1)), pick_hold(hmax), 1);
			hold_line(1'b0, 1'($urandom_range(0, 1)), pick_hold(hmax), 1);
		end
		if (done)
			hold_line(1'b1, 1'($urandom_range(0, 1)), 1, 1);
		else if (falls == 0)
			hold_line(1'b1, 1'b1, int'(lim_first) + 2, 0);
		else
			hold_line(1'b0, 1'b1, int'(lim_bit) + 2, 0);
	endtask

	function automatic int tx_slack();
		return $urandom_range(0, (lim_first > 7) ? 6 : int'(lim_first) - 1);
	endfunction

	// mostly well-formed frames with random content, some broken ones and raw noise
	task automatic random_traffic(input int budget);
		int stop_at, r, hmax, quiet;
		stop_at = fed_total + budget;
		hmax = (lim_bit < 6) ? int'(lim_bit) : 6;
		quiet = int'(lim_inhibit) + int'(lim_release) + int'(lim_first) + int'(lim_bit) + 4;
		while (fed_total < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				rx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 10, 1, hmax);
			end else if (r < 65) begin
				tx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, tx_slack(),
					11, 1, hmax);
			end else if (r < 80 && lim_bit <= 64) begin
				if ($urandom_range(0, 1))
					rx_frame(8'($urandom_range(0, 255)), 0, $urandom_range(0, 10), 0, hmax);
				else
					tx_frame(8'($urandom_range(0, 255)), 0, tx_slack(), $urandom_range(1, 10),
						0, hmax);
			end else if (r < 88 && lim_first <= 64) begin
				// device never clocks: first edge wait runs out
				tx_frame(8'($urandom_range(0, 255)), 0, int'(lim_first) + $urandom_range(0, 2),
					0, 0, hmax);
			end else if (quiet <= 300) begin
				repeat ($urandom_range(1, 12))
					feed($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				hold_line(1'b1, 1'b1, quiet, 0);
			end else begin
				rx_frame(8'($urandom_range(0, 255)), 0, 10, 1, hmax);
			end
			hold_line(1'b1, 1'b1, $urandom_range(0, 3), 0);
		end
	endtask

	// wait for every owed result, then idle the lines until the engine is idle too
	task automatic settle();
		do @(posedge clk); while (checked_total < fed_total);
		repeat (4) @(posedge clk);
	endtask

	task automatic settle_idle();
		settle();
		while (eng_ph != ps2hbt_pkg::PH_IDLE) begin
			hold_line(1'b1, 1'b1, 64, 0);
			settle();
		end
	endtask

	task automatic write_reg(input logic [ps2hbt_pkg::CFG_IDX_W-1:0] idx,
			input logic [ps2hbt_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ps2hbt_pkg::CFG_INHIBIT_TICKS: lim_inhibit = val;
			ps2hbt_pkg::CFG_RELEASE_TICKS: lim_release = val;
			ps2hbt_pkg::CFG_FIRST_TIMEOUT: lim_first = val;
			default: lim_bit = val;
		endcase
	endtask

	task automatic write_all(input logic [ps2hbt_pkg::CFG_W-1:0] inh,
			input logic [ps2hbt_pkg::CFG_W-1:0] rel,
			input logic [ps2hbt_pkg::CFG_W-1:0] first,
			input logic [ps2hbt_pkg::CFG_W-1:0] bitto);
		write_reg(ps2hbt_pkg::CFG_INHIBIT_TICKS, inh);
		write_reg(ps2hbt_pkg::CFG_RELEASE_TICKS, rel);
		write_reg(ps2hbt_pkg::CFG_FIRST_TIMEOUT, first);
		write_reg(ps2hbt_pkg::CFG_BIT_TIMEOUT, bitto);
	endtask

	// ------------------------------------------------------------- sequence
	initial begin
		engine_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// default timing: clean frames at the byte extremes, a parity error,
		// and a request on the same tick as a receive start
		rx_frame(8'h00, 0, 10, 1, 1);
		rx_frame(8'hFF, 1, 10, 1, 3);
		rx_frame(8'h01, 0, 10, 1, 2);
		rx_frame(8'h80, 0, 10, 1, 4);
		tx_frame(8'hFF, 0, 0, 11, 1, 2);
		tx_frame(8'h00, 1, 3, 11, 1, 1);
		settle_idle();

		// every limit at its minimum: no spare tick anywhere, then both tx timeouts
		write_all(16'd1, 16'd1, 16'd1, 16'd1);
		tx_frame(8'hC3, 0, 1, 0, 0, 1);
		tx_frame(8'h3C, 0, 0, 5, 0, 1);
		random_traffic(120);
		settle_idle();

		// short random limits; a stalled receive, then stall the result side hard
		// while requests keep coming
		write_all(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
			16'($urandom_range(2, 16)), 16'($urandom_range(2, 8)));
		rx_frame(8'h5A, 0, 4, 0, 2);
		random_traffic(150);
		long_hold_go <= 1'b1;
		settle_idle();

		// edge waits at their maximum with short padding: one full send and one receive
		write_all(16'd3, 16'd2, 16'hFFFF, 16'hFFFF);
		tx_frame(8'hA5, 0, 6, 11, 1, 6);
		rx_frame(8'h96, 0, 10, 1, 6);
		settle_idle();

		write_all(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
			16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
		random_traffic(100);
		settle_idle();

		if (due_results.size() != 0) begin
			$error("%0d line results never arrived", due_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// drop the run if the DUT hangs
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
